FILE: rtl/mpdr_pkg.sv
// Shared types and constants for the mesh packet deframe and relay block.
package mpdr_pkg;

	localparam int unsigned RESQ_DEPTH = 4;

	localparam logic [7:0] BCAST_BIT  = 8'h80;
	localparam logic [7:0] TTL_MASK   = 8'h0F;
	localparam logic [7:0] HIGH_MASK  = 8'hF0;
	localparam logic [7:0] BCAST_DEST = 8'd255;

	// register byte addresses on the configuration port
	localparam logic [2:0] ADDR_ROUTER_EN = 3'd0;

	typedef enum logic [2:0] {
		POS_LEN,
		POS_CTRL,
		POS_PID,
		POS_SRC,
		POS_DEST,
		POS_PAYLOAD
	} pos_t;

	typedef struct packed {
		logic [7:0] relay_byte;
		logic       relay_valid;
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic [7:0] ctrl_field;
		logic [7:0] pid_field;
		logic [7:0] source_node;
		logic [7:0] dest_node;
		logic       is_last;
		logic       header_short;
		logic [6:0] rssi_out;
	} res_t;

	// results produced by one accepted byte: cnt is 0, 1 or 2
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

FILE: rtl/mpdr_deframe.sv
// Per-byte header parser: tracks position, saves header fields, builds results.
module mpdr_deframe
	import mpdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	input  logic       byte_last,
	input  logic [6:0] rssi,
	input  logic       router_enable,
	output push_t      push
);

	pos_t       pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic [7:0] ctrl_q, ctrl_d;
	logic [7:0] pid_q, pid_d;
	logic [7:0] src_q, src_d;
	logic [7:0] dest_q, dest_d;
	logic       rel_q, rel_d;
	logic [6:0] rssi_q, rssi_d;
	logic       complete;

	// next state and saved header fields
	always_comb begin
		len_d  = len_q;
		ctrl_d = ctrl_q;
		pid_d  = pid_q;
		src_d  = src_q;
		dest_d = dest_q;
		rel_d  = rel_q;
		rssi_d = rssi_q;
		case (pos_q)
			POS_LEN: begin
				len_d  = rx_byte;
				rssi_d = rssi;
				ctrl_d = '0;
				pid_d  = '0;
				src_d  = '0;
				dest_d = BCAST_DEST;
				rel_d  = 1'b0;
			end
			POS_CTRL: begin
				ctrl_d = rx_byte;
				rel_d  = router_enable && ((rx_byte & TTL_MASK) != 8'd0);
			end
			POS_PID:  pid_d  = rx_byte;
			POS_SRC:  src_d  = rx_byte;
			POS_DEST: dest_d = rx_byte;
			default:  ;
		endcase

		case (pos_q)
			POS_SRC:     complete = (ctrl_q & BCAST_BIT) != 8'd0;
			POS_DEST,
			POS_PAYLOAD: complete = 1'b1;
			default:     complete = 1'b0;
		endcase

		pos_d = pos_q;
		if (byte_last) begin
			pos_d = POS_LEN;
		end else begin
			case (pos_q)
				POS_LEN:  pos_d = POS_CTRL;
				POS_CTRL: pos_d = POS_PID;
				POS_PID:  pos_d = POS_SRC;
				POS_SRC:  pos_d = complete ? POS_PAYLOAD : POS_DEST;
				POS_DEST: pos_d = POS_PAYLOAD;
				default:  pos_d = POS_PAYLOAD;
			endcase
		end
	end

	// results for this byte
	always_comb begin
		res_t base;
		base               = '0;
		base.ctrl_field    = ctrl_d;
		base.pid_field     = pid_d;
		base.source_node   = src_d;
		base.dest_node     = dest_d;
		base.rssi_out      = rssi_d;
		push.cnt           = 2'd0;
		push.r0            = base;
		push.r1            = base;
		if (byte_last && !complete) begin
			push.cnt             = 2'd1;
			push.r0.is_last      = 1'b1;
			push.r0.header_short = 1'b1;
		end else if (pos_q == POS_PAYLOAD) begin
			push.cnt              = 2'd1;
			push.r0.relay_byte    = rel_d ? rx_byte : 8'd0;
			push.r0.relay_valid   = rel_d;
			push.r0.payload_byte  = rx_byte;
			push.r0.payload_valid = 1'b1;
			push.r0.is_last       = byte_last;
		end else if (pos_q == POS_CTRL) begin
			// held length goes out first, then control with TTL one lower
			if (rel_d) begin
				push.cnt            = 2'd2;
				push.r0.relay_byte  = len_q;
				push.r0.relay_valid = 1'b1;
				push.r1.relay_byte  = {rx_byte[7:4], rx_byte[3:0] - 4'd1};
				push.r1.relay_valid = 1'b1;
			end
		end else if (pos_q != POS_LEN) begin
			if (rel_d) begin
				push.cnt            = 2'd1;
				push.r0.relay_byte  = rx_byte;
				push.r0.relay_valid = 1'b1;
				push.r0.is_last     = byte_last;
			end else if (byte_last) begin
				push.cnt        = 2'd1;
				push.r0.is_last = 1'b1;
			end
		end
		if (!take) begin
			push.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_LEN;
			len_q  <= '0;
			ctrl_q <= '0;
			pid_q  <= '0;
			src_q  <= '0;
			dest_q <= BCAST_DEST;
			rel_q  <= 1'b0;
			rssi_q <= '0;
		end else if (take) begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			ctrl_q <= ctrl_d;
			pid_q  <= pid_d;
			src_q  <= src_d;
			dest_q <= dest_d;
			rel_q  <= rel_d;
			rssi_q <= rssi_d;
		end
	end

	a_two_only_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (take && pos_q == POS_CTRL))
		else $error("two results from a byte other than control");

	a_short_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0 && push.r0.header_short) |-> byte_last)
		else $error("short header flagged on a byte that is not last");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_last) |=> (pos_q == POS_LEN))
		else $error("parser did not return to length byte after last");

	a_relay_needs_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		rel_q |-> ((ctrl_q & TTL_MASK) != 8'd0))
		else $error("relaying a packet whose TTL is zero");

endmodule

FILE: rtl/mpdr_resq.sv
// Small result queue: takes up to two results per cycle, hands out one.
module mpdr_resq
	import mpdr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	localparam int unsigned PW = $clog2(RESQ_DEPTH);
	localparam int unsigned CW = $clog2(RESQ_DEPTH + 1);

	res_t          mem_q [RESQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_nx;
	logic [CW-1:0] count_q;
	logic          pop;

	assign wr_nx     = wr_ptr_q + PW'(1);
	assign room      = count_q <= CW'(RESQ_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RESQ_DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (count_q <= CW'(RESQ_DEPTH - 2)))
		else $error("results pushed without room for two");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.cnt == 2'd0) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("queue count wrong after pop");

endmodule

FILE: rtl/mesh_packet_deframe_and_relay.sv
// Top level: mesh packet deframer and relay with stream ports and APB register.
//
// Input stream (s_*): one received packet byte per request, the length byte
// first; s_tlast marks the final byte, rssi is taken with the length byte.
// Output stream (m_*): results carrying relay and payload bytes together with
// the header fields seen so far; m_tlast marks the last result of a packet.
// A control byte of a relayed packet yields two results (held length, then
// control with TTL decremented); other header bytes yield one or none.
// A byte's results are written into the result queue as the byte is accepted.
// Throughput: one byte per cycle while the receiver keeps up; output is one
// result per cycle, set by the four-entry result queue.
// s_tready drops when fewer than two queue entries are free, so a stalled
// receiver back-pressures the input once three or four results are buffered.
// Reset clears the parser to wait for a length byte, empties the queue and
// turns router mode off. router_enable lives at APB byte address 0; it is to be
// written only while the block is idle, which the block itself does not enforce.
module mesh_packet_deframe_and_relay
	import mpdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [7:0] rx_byte, [14:8] rssi, [15] zero
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	// m_tdata: [7:0] relay_byte, [15:8] payload_byte, [23:16] ctrl_field,
	//          [31:24] pid_field, [39:32] source_node, [47:40] dest_node,
	//          [54:48] rssi_out, [55] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	output logic        m_tlast,
	// m_tuser: [0] relay_valid, [1] payload_valid, [2] header_short
	output logic [2:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic  router_enable_q;
	logic  take;
	push_t push;
	res_t  res;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ROUTER_EN) ? {31'd0, router_enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_ROUTER_EN) begin
			router_enable_q <= pwdata[0];
		end
	end

	assign take = s_tvalid && s_tready;

	mpdr_deframe u_deframe (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.rx_byte       (s_tdata[7:0]),
		.byte_last     (s_tlast),
		.rssi          (s_tdata[14:8]),
		.router_enable (router_enable_q),
		.push          (push)
	);

	mpdr_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.rssi_out, res.dest_node, res.source_node, res.pid_field,
		res.ctrl_field, res.payload_byte, res.relay_byte};
	assign m_tlast = res.is_last;
	assign m_tuser = {res.header_short, res.payload_valid, res.relay_valid};

	a_tdata_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser[0] || !m_tuser[2]))
		else $error("relay byte on a short header result");

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> m_tlast)
		else $error("short header result not marked last");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[15:8] == 8'd0))
		else $error("payload byte nonzero without payload flag");

endmodule

FILE: tb/sv/mpdr_deframe_watch.sv
// Stream and register monitor for the deframer: predicts every result and compares it.
module mpdr_deframe_watch
	import mpdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tlast,
	input  logic [2:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          results_due
);

	pos_t       parse_pos;
	logic [7:0] hold_len;
	logic [7:0] hdr_ctrl;
	logic [7:0] hdr_pid;
	logic [7:0] hdr_src;
	logic [7:0] hdr_dest;
	logic       relay_on;
	logic       router_on;
	logic [6:0] pkt_rssi;
	res_t       due_results [$];

	function automatic void queue_result(input logic [7:0] rb, input logic rv,
			input logic [7:0] pb, input logic pv, input logic lst, input logic shrt);
		res_t r;
		r.relay_byte    = rv ? rb : 8'h00;
		r.relay_valid   = rv;
		r.payload_byte  = pv ? pb : 8'h00;
		r.payload_valid = pv;
		r.ctrl_field    = hdr_ctrl;
		r.pid_field     = hdr_pid;
		r.source_node   = hdr_src;
		r.dest_node     = hdr_dest;
		r.is_last       = lst;
		r.header_short  = shrt;
		r.rssi_out      = pkt_rssi;
		due_results.push_back(r);
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b, input logic last,
			input logic [6:0] rssi);
		pos_t       at;
		logic       hdr_done;
		logic [3:0] ttl_dec;
		at = parse_pos;
		case (at)
			POS_LEN: begin
				hold_len = b;
				pkt_rssi = rssi;
				hdr_ctrl = 8'h00;
				hdr_pid  = 8'h00;
				hdr_src  = 8'h00;
				hdr_dest = BCAST_DEST;
				relay_on = 1'b0;
			end
			POS_CTRL: begin
				hdr_ctrl = b;
				relay_on = router_on && ((b & TTL_MASK) != 8'h00);
			end
			POS_PID:  hdr_pid = b;
			POS_SRC:  hdr_src = b;
			POS_DEST: hdr_dest = b;
			default: ;
		endcase

		// broadcast headers end at the source byte, point-to-point at the destination
		if (at == POS_PAYLOAD || at == POS_DEST)
			hdr_done = 1'b1;
		else if (at == POS_SRC)
			hdr_done = (hdr_ctrl & BCAST_BIT) != 8'h00;
		else
			hdr_done = 1'b0;

		if (last) begin
			parse_pos = POS_LEN;
			if (!hdr_done) begin
				queue_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
				return;
			end
		end else if (at == POS_SRC) begin
			parse_pos = hdr_done ? POS_PAYLOAD : POS_DEST;
		end else if (at != POS_PAYLOAD) begin
			parse_pos = pos_t'(at + 1);
		end

		if (at == POS_PAYLOAD) begin
			queue_result(b, relay_on, b, 1'b1, last, 1'b0);
		end else if (at == POS_CTRL) begin
			// held length goes out first, then control with TTL one lower
			if (relay_on) begin
				ttl_dec = b[3:0] - 4'd1;
				queue_result(hold_len, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
				queue_result((b & HIGH_MASK) | {4'h0, ttl_dec}, 1'b1, 8'h00, 1'b0,
					1'b0, 1'b0);
			end
		end else if (at != POS_LEN) begin
			if (relay_on)
				queue_result(b, 1'b1, 8'h00, 1'b0, last, 1'b0);
			else if (last)
				queue_result(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
		end
	endtask

	task automatic check_field(input string fname, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_cycle
		res_t want;
		res_t got;
		if (!arst_n) begin
			parse_pos   = POS_LEN;
			hold_len    = 8'h00;
			hdr_ctrl    = 8'h00;
			hdr_pid     = 8'h00;
			hdr_src     = 8'h00;
			hdr_dest    = BCAST_DEST;
			relay_on    = 1'b0;
			router_on   = 1'b0;
			pkt_rssi    = 7'h00;
			fail_count  = 0;
			due_results.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ROUTER_EN)
				router_on = pwdata[0];

			if (m_tvalid && m_tready) begin
				got.relay_byte    = m_tdata[7:0];
				got.payload_byte  = m_tdata[15:8];
				got.ctrl_field    = m_tdata[23:16];
				got.pid_field     = m_tdata[31:24];
				got.source_node   = m_tdata[39:32];
				got.dest_node     = m_tdata[47:40];
				got.rssi_out      = m_tdata[54:48];
				got.is_last       = m_tlast;
				got.relay_valid   = m_tuser[0];
				got.payload_valid = m_tuser[1];
				got.header_short  = m_tuser[2];
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual tdata %h tlast %b tuser %b",
						$time, m_tdata, m_tlast, m_tuser);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("relay_byte", want.relay_byte, got.relay_byte);
					check_field("relay_valid", 8'(want.relay_valid), 8'(got.relay_valid));
					check_field("payload_byte", want.payload_byte, got.payload_byte);
					check_field("payload_valid", 8'(want.payload_valid),
						8'(got.payload_valid));
					check_field("ctrl_field", want.ctrl_field, got.ctrl_field);
					check_field("pid_field", want.pid_field, got.pid_field);
					check_field("source_node", want.source_node, got.source_node);
					check_field("dest_node", want.dest_node, got.dest_node);
					check_field("is_last", 8'(want.is_last), 8'(got.is_last));
					check_field("header_short", 8'(want.header_short),
						8'(got.header_short));
					check_field("rssi_out", 8'(want.rssi_out), 8'(got.rssi_out));
				end
			end

			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata[7:0], s_tlast, s_tdata[14:8]);
		end
		results_due = due_results.size();
	end

endmodule

FILE: tb/sv/mesh_packet_deframe_and_relay_test.sv
// Top of the deframer testbench: clock, reset, packet stimulus, back-pressure and verdict.
module mesh_packet_deframe_and_relay_test
	import mpdr_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_BYTES = 190;
	localparam int N_PHASES = 6;
	// router mode per phase, bit 0 first
	localparam logic [N_PHASES-1:0] ROUTER_PLAN = 6'b101101;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          results_due;
	bit          calm;
	bit          hold_off_req;
	logic [7:0]  frame [$];

	mesh_packet_deframe_and_relay dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mpdr_deframe_watch watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stall bursts, one long hold-off on request, none when calm
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck = 0;
			else
				stuck++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last, input logic [6:0] rssi);
		if (!calm && $urandom_range(0, 11) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, rssi, b};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input logic [6:0] rssi0);
		int i;
		for (i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1, (i == 0) ? rssi0 : 7'($urandom));
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_due == 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly complete packets with random content, some cut inside the header
	task automatic build_random_frame();
		logic [7:0] ctrl;
		int         hdr_len;
		int         n;
		int         pick;
		int         i;
		ctrl = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25)
			ctrl[3:0] = 4'h0;
		else if (pick < 35)
			ctrl[3:0] = 4'h1;
		else if (pick < 40)
			ctrl[3:0] = 4'hF;
		hdr_len = ctrl[7] ? 4 : 5;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			n = $urandom_range(1, hdr_len - 1);
		else if (pick < 20)
			n = hdr_len + $urandom_range(7, 20);
		else
			n = hdr_len + $urandom_range(0, 6);
		frame.delete();
		frame.push_back($urandom_range(0, 1) ? 8'(n - 1) : 8'($urandom));
		for (i = 1; i < n; i++)
			frame.push_back((i == 1) ? ctrl : 8'($urandom));
	endtask

	initial begin : stimulus
		int phase;
		int phase_bytes;
		int frames;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 16'h0000;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= 3'd0;
		pwdata   <= 32'h0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// router off: broadcast ending at source, point-to-point with one payload byte
		frame = '{8'hFF, 8'h8F, 8'h00, 8'hFF};
		send_frame(7'h7F);
		frame = '{8'h00, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF};
		send_frame(7'h00);
		drain(4);
		reg_write(ADDR_ROUTER_EN, 32'd1);
		// relayed broadcast, then zero TTL cut at pid
		frame = '{8'h05, 8'h8F, 8'h12, 8'h34, 8'hAA};
		send_frame(7'h55);
		frame = '{8'h03, 8'h70, 8'h00};
		send_frame(7'h2A);
		// TTL 1 point-to-point cut before destination: aborted relay
		frame = '{8'h04, 8'h01, 8'h22, 8'h33};
		send_frame(7'h01);
		// packet of just a length byte, then one ending on its control byte
		frame = '{8'h7F};
		send_frame(7'h40);
		frame = '{8'h80, 8'h3F};
		send_frame(7'h3F);

		for (phase = 0; phase < N_PHASES; phase++) begin
			drain(4);
			reg_write(ADDR_ROUTER_EN, {31'd0, ROUTER_PLAN[phase]});
			calm = (phase == N_PHASES - 1);
			phase_bytes = 0;
			frames = 0;
			while (phase_bytes < PHASE_BYTES) begin
				if (phase == 2 && frames == 3)
					hold_off_req = 1'b1;
				if (phase == 3 && frames == 10)
					drain(1);
				build_random_frame();
				send_frame(7'($urandom));
				phase_bytes += frame.size();
				frames++;
			end
		end

		drain(10);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
